[rtl/mi_pkg.sv]
// Package for the modular inverse unit: widths, payload structs, status codes and states.
`default_nettype none
package mi_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CntWidth  = $clog2(DataWidth);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_INVERSE = 2'd1,
    ST_TOO_SMALL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmLoop,
    FsmDiv,
    FsmFinish
  } fsm_e;

  typedef struct packed {
    logic [DataWidth-1:0] number;
    logic [DataWidth-1:0] modulus;
  } in_beat_t;

  typedef struct packed {
    logic [DataWidth-1:0] inverse;
    logic [1:0]           status;
  } out_beat_t;

endpackage
`default_nettype wire

[rtl/mi_div_unit.sv]
// Radix-2 serial divider that also accumulates quotient times a coefficient.
`default_nettype none
module mi_div_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [mi_pkg::DataWidth-1:0] dividend_i,
  input  wire logic [mi_pkg::DataWidth-1:0] divisor_i,
  input  wire logic [mi_pkg::DataWidth-1:0] coef_i,
  output logic                             done_o,
  output logic [mi_pkg::DataWidth-1:0]     rem_o,
  output logic [mi_pkg::DataWidth-1:0]     prod_o
);
  import mi_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [DataWidth-1:0] dvd_q, dvd_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] acc_q, acc_d;
  logic [DataWidth:0]   trial;
  logic [DataWidth:0]   diff;
  logic                 qbit;

  assign trial = {rem_q, dvd_q[DataWidth-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign qbit  = ~diff[DataWidth];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DataWidth-2:0], 1'b0};
      rem_d = qbit ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
      acc_d = {acc_q[DataWidth-2:0], 1'b0} + (qbit ? coef_i : '0);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntWidth'(DataWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

[rtl/modular_inverse_unit.sv]
// Top level of the modular inverse unit: Euclid sequencer, coefficient registers and output stage.
//
// Usage: an input beat carries a number and a modulus; each yields one output beat
// with the inverse of the number modulo the modulus and a status (success, no
// inverse, or number not below modulus). The inverse reads zero unless the status
// is success. Both channels use valid and ready.
// Each Euclid step runs one radix-2 division in the serial divider, followed by a
// pass through the loop state that starts the next division or finishes. 32-bit
// operands need at most 45 steps. Items whose number is zero or not below the
// modulus skip the divider and go straight to the finish state.
// The unit works on one item at a time and accepts a new beat while idle, even
// while the previous result still waits in the output register. If the receiver
// stalls, the finished result of the next item is held back until the output
// register drains. Reset returns the sequencer to idle and empties the output.
`default_nettype none
module modular_inverse_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mi_pkg::in_beat_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mi_pkg::out_beat_t      out_data_o
);
  import mi_pkg::*;

  fsm_e                 state_q, state_d;
  status_e              sts_q, sts_d;
  logic [DataWidth-1:0] mod_q, r0_q, r1_q, a0_q, a1_q;
  logic                 neg0_q, neg1_q;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_data_q, out_data_d;

  logic                 in_fire;
  logic                 div_start;
  logic                 div_done;
  logic [DataWidth-1:0] div_rem;
  logic [DataWidth-1:0] div_prod;
  logic                 out_free;
  logic                 finish_fire;

  mi_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (r0_q),
    .divisor_i  (r1_q),
    .coef_i     (a1_q),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  assign out_free    = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;
  assign finish_fire = (state_q == FsmFinish) & out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle: begin
        if (in_valid_i) begin
          if (in_data_i.number >= in_data_i.modulus || in_data_i.number == '0) begin
            state_d = FsmFinish;
          end else begin
            state_d = FsmLoop;
          end
        end
      end
      FsmLoop: begin
        state_d = (r1_q == '0) ? FsmFinish : FsmDiv;
      end
      FsmDiv: begin
        if (div_done) begin
          state_d = FsmLoop;
        end
      end
      FsmFinish: begin
        if (out_free) begin
          state_d = FsmIdle;
        end
      end
      default: state_d = FsmIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      FsmIdle:   in_ready_o = 1'b1;
      FsmLoop:   div_start  = (r1_q != '0);
      FsmDiv:    div_start  = 1'b0;
      FsmFinish: div_start  = 1'b0;
      default:   in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    sts_d = sts_q;
    if (in_fire) begin
      if (in_data_i.number >= in_data_i.modulus) begin
        sts_d = ST_TOO_SMALL;
      end else if (in_data_i.number == '0) begin
        sts_d = ST_NO_INVERSE;
      end else begin
        sts_d = ST_OK;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    if (finish_fire) begin
      out_valid_d = 1'b1;
      if (sts_q != ST_OK) begin
        out_data_d.inverse = '0;
        out_data_d.status  = sts_q;
      end else if (r0_q != DataWidth'(1)) begin
        out_data_d.inverse = '0;
        out_data_d.status  = ST_NO_INVERSE;
      end else begin
        out_data_d.inverse = neg0_q ? (mod_q - a0_q) : a0_q;
        out_data_d.status  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sts_q      <= sts_d;
    out_data_q <= out_data_d;
    if (in_fire) begin
      mod_q  <= in_data_i.modulus;
      r0_q   <= in_data_i.modulus;
      r1_q   <= in_data_i.number;
      a0_q   <= '0;
      a1_q   <= DataWidth'(1);
      neg0_q <= 1'b0;
      neg1_q <= 1'b0;
    end else if (state_q == FsmDiv && div_done) begin
      r0_q   <= r1_q;
      r1_q   <= div_rem;
      a0_q   <= a1_q;
      a1_q   <= a0_q + div_prod;
      neg0_q <= neg1_q;
      neg1_q <= ~neg1_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the modular inverse unit, with directed and random operands.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mi_pkg::*;

  localparam int unsigned IdleLimit = 10000;
  localparam int unsigned ReportMax = 10;
  localparam int unsigned RandomItems = 400;
  localparam logic [DataWidth-1:0] BigPrime = 32'hFFFF_FFFB;
  localparam logic [DataWidth-1:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct {
    in_beat_t  operands;
    out_beat_t want;
  } inverse_job_t;

  typedef struct {
    logic [DataWidth-1:0] number;
    logic [DataWidth-1:0] modulus;
    bit                   known;
    out_beat_t            want;
  } table_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  bit        cur_known;
  out_beat_t cur_want;
  bit        steady;

  inverse_job_t pending_inverses[$];
  table_row_t   operand_table[$];
  int unsigned  mismatches;
  int unsigned  idle_cycles;

  modular_inverse_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic out_beat_t mod_inverse(logic [DataWidth-1:0] number,
                                            logic [DataWidth-1:0] modulus);
    logic [63:0] rem_prev, rem_cur, rem_next;
    logic [63:0] coef_prev, coef_cur, coef_next;
    logic [63:0] quot;
    bit          neg_prev, neg_cur;
    out_beat_t   res;
    res = '0;
    res.status = ST_OK;
    if (number >= modulus) begin
      res.status = ST_TOO_SMALL;
    end else if (number == '0) begin
      res.status = ST_NO_INVERSE;
    end else begin
      rem_prev  = 64'(modulus);
      rem_cur   = 64'(number);
      coef_prev = 64'd0;
      coef_cur  = 64'd1;
      neg_prev  = 1'b0;
      neg_cur   = 1'b0;
      while (rem_cur != 64'd0) begin
        quot      = rem_prev / rem_cur;
        rem_next  = rem_prev - quot * rem_cur;
        coef_next = coef_prev + quot * coef_cur;
        rem_prev  = rem_cur;
        rem_cur   = rem_next;
        coef_prev = coef_cur;
        coef_cur  = coef_next;
        neg_prev  = neg_cur;
        neg_cur   = !neg_cur;
      end
      if (rem_prev != 64'd1) begin
        res.status = ST_NO_INVERSE;
      end else if (neg_prev) begin
        res.inverse = DataWidth'(64'(modulus) - coef_prev);
      end else begin
        res.inverse = DataWidth'(coef_prev);
      end
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99, 0);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(120, 30);
  endfunction

  task automatic add_row(logic [DataWidth-1:0] number, logic [DataWidth-1:0] modulus,
                         bit known, logic [DataWidth-1:0] inverse, status_e status);
    table_row_t row;
    row.number         = number;
    row.modulus        = modulus;
    row.known          = known;
    row.want.inverse   = inverse;
    row.want.status    = status;
    operand_table.push_back(row);
  endtask

  task automatic drive_operands(logic [DataWidth-1:0] number, logic [DataWidth-1:0] modulus,
                                bit known, out_beat_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_data_i.number  <= number;
    in_data_i.modulus <= modulus;
    cur_known         <= known;
    cur_want          <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Output beats are checked before the input beat of the same edge is queued.
  always @(posedge clk_i) begin
    inverse_job_t job;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_inverses.size() == 0) begin
          if (mismatches < ReportMax)
            $display("unexpected beat: inverse %h status %0d",
                     out_data_o.inverse, out_data_o.status);
          mismatches++;
        end else begin
          job = pending_inverses.pop_front();
          if (out_data_o.inverse !== job.want.inverse ||
              out_data_o.status !== job.want.status) begin
            if (mismatches < ReportMax)
              $display("mismatch: number %h modulus %h expected %h/%0d got %h/%0d",
                       job.operands.number, job.operands.modulus,
                       job.want.inverse, job.want.status,
                       out_data_o.inverse, out_data_o.status);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        job.operands = in_data_i;
        job.want = cur_known ? cur_want : mod_inverse(in_data_i.number, in_data_i.modulus);
        pending_inverses.push_back(job);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  end

  initial begin
    logic [DataWidth-1:0] number, modulus;
    int unsigned          roll, shift, factor, big_part, low_part;
    out_beat_t            none;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cur_known   = 1'b0;
    cur_want    = '0;
    steady      = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    none        = '0;

    add_row(32'd0,       32'd0,       1'b1, 32'd0,       ST_TOO_SMALL);
    add_row(32'd5,       32'd0,       1'b1, 32'd0,       ST_TOO_SMALL);
    add_row(AllOnes,     32'd0,       1'b1, 32'd0,       ST_TOO_SMALL);
    add_row(32'd1,       32'd1,       1'b1, 32'd0,       ST_TOO_SMALL);
    add_row(32'd7,       32'd7,       1'b1, 32'd0,       ST_TOO_SMALL);
    add_row(AllOnes,     AllOnes,     1'b1, 32'd0,       ST_TOO_SMALL);
    add_row(32'd0,       32'd1,       1'b1, 32'd0,       ST_NO_INVERSE);
    add_row(32'd0,       32'd7,       1'b1, 32'd0,       ST_NO_INVERSE);
    add_row(32'd0,       AllOnes,     1'b1, 32'd0,       ST_NO_INVERSE);
    add_row(32'd6,       32'd9,       1'b1, 32'd0,       ST_NO_INVERSE);
    add_row(32'd4,       32'd8,       1'b1, 32'd0,       ST_NO_INVERSE);
    add_row(32'd2,       32'hFFFF_FFFE, 1'b1, 32'd0,     ST_NO_INVERSE);
    add_row(32'd1,       32'd2,       1'b1, 32'd1,       ST_OK);
    add_row(32'd1,       32'd7,       1'b1, 32'd1,       ST_OK);
    add_row(32'd1,       AllOnes,     1'b1, 32'd1,       ST_OK);
    add_row(32'hFFFF_FFFE, AllOnes,   1'b1, 32'hFFFF_FFFE, ST_OK);
    add_row(32'd2,       32'd3,       1'b0, 32'd0,       ST_OK);
    add_row(32'd3,       32'd7,       1'b0, 32'd0,       ST_OK);
    add_row(32'd12345,   BigPrime,    1'b0, 32'd0,       ST_OK);
    add_row(32'hFFFF_FFFA, BigPrime,  1'b0, 32'd0,       ST_OK);
    add_row(32'h8000_0000, AllOnes,   1'b0, 32'd0,       ST_OK);
    add_row(32'd1836311903, 32'd2971215073, 1'b0, 32'd0, ST_OK);
    add_row(32'h5555_5555, 32'hAAAA_AAAB, 1'b0, 32'd0,   ST_OK);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (operand_table[i])
      drive_operands(operand_table[i].number, operand_table[i].modulus,
                     operand_table[i].known, operand_table[i].want);

    for (int unsigned item = 0; item < RandomItems; item++) begin
      steady = (item >= 150 && item < 200);
      if (item == 100 || item == 300) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_inverses.size() != 0) @(posedge clk_i);
      end
      roll = $urandom_range(99, 0);
      if (roll < 50) begin
        modulus = $urandom;
        number  = (modulus != '0) ? $urandom % modulus : '0;
      end else if (roll < 65) begin
        shift   = $urandom_range(30, 0);
        modulus = $urandom >> shift;
        number  = (modulus != '0) ? $urandom % modulus : '0;
      end else if (roll < 75) begin
        factor   = $urandom_range(65535, 2);
        big_part = $urandom_range(65535, 2);
        low_part = $urandom_range(big_part - 1, 1);
        modulus  = DataWidth'(factor * big_part);
        number   = DataWidth'(factor * low_part);
      end else if (roll < 83) begin
        modulus = BigPrime;
        number  = $urandom_range(BigPrime - 1, 1);
      end else if (roll < 90) begin
        number  = $urandom;
        modulus = $urandom_range(number, 0);
      end else if (roll < 95) begin
        number  = $urandom_range(1, 0);
        modulus = $urandom;
      end else begin
        number  = $urandom;
        modulus = $urandom;
      end
      drive_operands(number, modulus, 1'b0, none);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending_inverses.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && pending_inverses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
